// ===== hw/rtl/address_frequency_counter_top_macros.svh =====
// Assertion helpers; empty when SYNTH is defined.
`ifndef ADDRESS_FREQUENCY_COUNTER_TOP_MACROS_SVH
`define ADDRESS_FREQUENCY_COUNTER_TOP_MACROS_SVH

`ifndef SYNTH
`define AFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/afc_pkg.sv =====
package afc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 32;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== hw/rtl/afc_table.sv =====
module afc_table import afc_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/address_frequency_counter_top.sv =====
// Address frequency counter. Keeps up to TABLE_DEPTH distinct 32-bit addresses, sorted
// ascending, with a saturating count each, in one single-port-read table memory. A count
// item binary-searches the table until the range is empty; a miss then shifts every
// larger entry up one slot, entry by entry, and writes the new one. A full table drops new
// addresses and sets a sticky flag shown on every entry of the next dump. A finish item
// emits the n entries by count descending, ties by ascending address, each found by one
// selection pass over the table memory; the table and the flag are cleared when the last
// entry is loaded into the output register. o_ready is high only while no item is in
// progress.
`include "address_frequency_counter_top_macros.svh"

module address_frequency_counter_top import afc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [KEY_W-1:0]   i_ip_address,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [KEY_W-1:0]   o_out_address,
    output logic [COUNT_W-1:0] o_out_count,
    output logic               o_last_entry,
    output logic               o_dropped_any
);

    typedef enum logic [2:0] {
        S_IDLE, S_SR_RD, S_SR_CMP, S_SH_RD, S_SH_WR, S_INS, S_SCAN, S_EMIT
    } t_state;

    t_state             r_state;
    logic [KEY_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [IDX_W-1:0]   r_mid;
    logic [CNT_W-1:0]   r_sh;
    logic [CNT_W-1:0]   r_total;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_best_vld;
    t_entry             r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic [COUNT_W-1:0] r_prev_cnt;
    logic [IDX_W-1:0]   r_prev_idx;
    logic [CNT_W-1:0]   r_emitted;
    logic               r_o_valid;
    logic [KEY_W-1:0]   r_out_address;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_last;
    logic               r_dropped;

    t_ram_req           ram_req;
    t_entry             rdata;
    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [CNT_W-1:0]   sh_m1;
    logic               out_free;
    logic               key_eq;
    logic               key_gt;
    logic [COUNT_W-1:0] cnt_inc;
    logic               eligible;
    logic               better;
    logic               emit_last;

    afc_table u_table (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[IDX_W:1];
    assign sh_m1     = r_sh - 1'b1;
    assign out_free  = !r_o_valid || i_ready;
    assign key_eq    = rdata.key == r_addr;
    assign key_gt    = rdata.key > r_addr;
    assign cnt_inc   = (rdata.count == '1) ? rdata.count : rdata.count + 1'b1;
    // next in order must rank strictly below the entry emitted last
    assign eligible  = (r_emitted == '0) || (rdata.count < r_prev_cnt) ||
                       ((rdata.count == r_prev_cnt) && (r_pend_idx > r_prev_idx));
    assign better    = !r_best_vld || (rdata.count > r_best.count);
    assign emit_last = (r_emitted + 1'b1) == r_total;

    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.waddr = r_mid;
        ram_req.wdata = '{key: r_addr, count: COUNT_W'(1)};
        ram_req.raddr = mid;
        unique case (r_state)
            S_SR_CMP: begin
                ram_req.we    = key_eq;
                ram_req.wdata = '{key: rdata.key, count: cnt_inc};
            end
            S_SH_RD: begin
                ram_req.raddr = sh_m1[IDX_W-1:0];
            end
            S_SH_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_sh[IDX_W-1:0];
                ram_req.wdata = rdata;
            end
            S_INS: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_lo[IDX_W-1:0];
            end
            S_SCAN: begin
                ram_req.raddr = r_rd_idx[IDX_W-1:0];
            end
            S_IDLE, S_SR_RD, S_EMIT: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_ovf      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pend     <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr <= i_ip_address;
                        if (i_cmd == CMD_FINISH) begin
                            r_emitted  <= '0;
                            r_rd_idx   <= '0;
                            r_pend     <= 1'b0;
                            r_best_vld <= 1'b0;
                            if (r_total == '0) begin
                                r_ovf <= 1'b0;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= r_total;
                            r_state <= S_SR_RD;
                        end
                    end
                end
                S_SR_RD: begin
                    if (r_lo == r_hi) begin
                        if (r_total == CNT_W'(TABLE_DEPTH)) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_lo == r_total) begin
                            r_state <= S_INS;
                        end else begin
                            r_sh    <= r_total;
                            r_state <= S_SH_RD;
                        end
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_SR_CMP;
                    end
                end
                S_SR_CMP: begin
                    if (key_eq) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (key_gt) begin
                            r_hi <= CNT_W'(r_mid);
                        end else begin
                            r_lo <= CNT_W'(r_mid) + 1'b1;
                        end
                        r_state <= S_SR_RD;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_sh <= sh_m1;
                    if (sh_m1 == r_lo) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_INS: begin
                    r_total <= r_total + 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_rd_idx != r_total) begin
                        r_rd_idx   <= r_rd_idx + 1'b1;
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx[IDX_W-1:0];
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && eligible && better) begin
                        r_best_vld <= 1'b1;
                        r_best     <= rdata;
                        r_best_idx <= r_pend_idx;
                    end
                    if (!r_pend && (r_rd_idx == r_total)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid     <= 1'b1;
                        r_out_address <= r_best.key;
                        r_out_count   <= r_best.count;
                        r_last        <= emit_last;
                        r_dropped     <= r_ovf;
                        r_prev_cnt    <= r_best.count;
                        r_prev_idx    <= r_best_idx;
                        r_emitted     <= r_emitted + 1'b1;
                        r_rd_idx      <= '0;
                        r_best_vld    <= 1'b0;
                        if (emit_last) begin
                            r_total <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
            endcase
        end
    end

    assign o_ready       = r_state == S_IDLE;
    assign o_valid       = r_o_valid;
    assign o_out_address = r_out_address;
    assign o_out_count   = r_out_count;
    assign o_last_entry  = r_last;
    assign o_dropped_any = r_dropped;

    `AFC_ASSERT_SAME(a_search_bounds, i_clk, i_rst_n, r_state == S_SR_RD, (r_lo <= r_hi) && (r_hi <= r_total))
    `AFC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, (r_state == S_EMIT) && out_free && emit_last, (r_total == '0) && !r_ovf && o_ready && o_last_entry)
    `AFC_ASSERT_SAME(a_scan_best, i_clk, i_rst_n, r_state == S_EMIT, r_best_vld && (r_emitted < r_total))
    `AFC_ASSERT_SAME(a_total_bound, i_clk, i_rst_n, o_ready, r_total <= CNT_W'(TABLE_DEPTH))

endmodule
